>>> sv/npcm_pkg.sv
package npcm_pkg;

  localparam int PALETTE_DEPTH = 512;
  localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOR_W       = 8;
  localparam int ENTRY_W       = 3 * COLOR_W;
  localparam int OUT_IDX_W     = 9;
  localparam int DIST_W        = 18;
  localparam int SQ_W          = 2 * COLOR_W;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 18'd2048;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] match_index;
    logic                 found;
    logic [DIST_W-1:0]    distance;
    logic                 status;
  } out_beat_t;

  // low bits of a palette index, zero padded when the index is narrow
  function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

>>> sv/npcm_ram.sv
module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/nearest_palette_color_match.sv
// nearest palette color match: holds up to PALETTE_DEPTH rgb entries in a
// single-port-write / single-port-read ram and answers one operation per
// input beat with exactly one result beat. clear empties the palette and
// zeroes the last match. append writes the next free entry in the accept
// cycle and returns its index, or status full when the palette is full.
// query streams the stored entries out of the ram read port, one per
// cycle, squares the per-channel differences in one stage and sums and
// compares in the next; a distance at or below the running limit (start
// value cfg threshold) takes the match, so ties go to the later entry.
// with no match the previous match index comes back with found 0. a new
// beat is taken only once the previous result has moved into the output
// register; the output register holds a result while out_stall is high,
// and the block may accept the next item meanwhile. the user must write
// the threshold through the cfg port only while idle; nothing in the block
// enforces this. no clearing pass: entries past the fill count are never
// read.
module nearest_palette_color_match (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  npcm_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output npcm_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [npcm_pkg::DIST_W-1:0]          cfg_data
);

  import npcm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    logic [SQ_W-1:0]    w;
    d = (a > b) ? (a - b) : (b - a);
    w = {{COLOR_W{1'b0}}, d};
    return w * w;
  endfunction

  // control and config
  logic [1:0]         state_r;
  logic [DIST_W-1:0]  threshold_r;
  logic [CNT_W-1:0]   entry_count_r;
  logic [IDX_W-1:0]   last_match_r;

  // query context
  logic [COLOR_W-1:0] q_red_r, q_green_r, q_blue_r;
  logic [CNT_W-1:0]   scan_idx_r;
  logic [DIST_W-1:0]  limit_r;
  logic [IDX_W-1:0]   match_r;
  logic               found_r;

  // scan pipeline: ram data stage, squares stage
  logic               v1_r, v2_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r;
  logic [SQ_W-1:0]    sq_red_r, sq_green_r, sq_blue_r;

  // result waiting for the output register
  out_beat_t          pend_r;
  out_beat_t          out_r;
  logic               out_valid_r;

  logic               in_accept;
  logic               issue;
  logic               scan_done;
  logic               out_free;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [DIST_W-1:0]  dist_sum;
  logic               has_room;
  out_beat_t          accept_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign has_room  = (entry_count_r < CNT_W'(PALETTE_DEPTH));
  assign ram_we    = in_accept && (in_data.operation == OP_APPEND) && has_room;

  assign issue     = (state_r == ST_SCAN) && (scan_idx_r < entry_count_r);
  assign scan_done = (state_r == ST_SCAN) && !issue && !v1_r && !v2_r;

  assign dist_sum  = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

  // result of a clear, append or unused code, known at accept
  always_comb begin
    accept_res = '0;
    if (in_data.operation == OP_APPEND) begin
      if (has_room) begin
        accept_res.match_index = to_out_index(entry_count_r[IDX_W-1:0]);
      end else begin
        accept_res.status = STATUS_FULL;
      end
    end
  end

  npcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (entry_count_r[IDX_W-1:0]),
    .wr_data ({in_data.red, in_data.green, in_data.blue}),
    .rd_en   (issue),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      threshold_r   <= THRESHOLD_RESET;
      entry_count_r <= '0;
      last_match_r  <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end

      // pipeline valids
      v1_r <= issue;
      v2_r <= v1_r;

      // output register loads from finish, drains on a taken beat
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_data.operation)
              OP_CLEAR: begin
                entry_count_r <= '0;
                last_match_r  <= '0;
                state_r       <= ST_FINISH;
              end
              OP_APPEND: begin
                if (has_room) begin
                  entry_count_r <= entry_count_r + CNT_W'(1);
                end
                state_r <= ST_FINISH;
              end
              OP_QUERY: begin
                state_r <= ST_SCAN;
              end
              default: begin
                state_r <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            last_match_r <= match_r;
            state_r      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    idx1_r     <= scan_idx_r[IDX_W-1:0];
    idx2_r     <= idx1_r;
    sq_red_r   <= sq_diff(ram_rdata[3*COLOR_W-1:2*COLOR_W], q_red_r);
    sq_green_r <= sq_diff(ram_rdata[2*COLOR_W-1:COLOR_W], q_green_r);
    sq_blue_r  <= sq_diff(ram_rdata[COLOR_W-1:0], q_blue_r);

    if (issue) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
    end

    // running compare, ties go to the later entry
    if (v2_r && (dist_sum <= limit_r)) begin
      limit_r <= dist_sum;
      match_r <= idx2_r;
      found_r <= 1'b1;
    end

    if (in_accept) begin
      q_red_r    <= in_data.red;
      q_green_r  <= in_data.green;
      q_blue_r   <= in_data.blue;
      scan_idx_r <= '0;
      limit_r    <= threshold_r;
      match_r    <= last_match_r;
      found_r    <= 1'b0;
      pend_r     <= accept_res;
    end

    if (scan_done) begin
      pend_r.match_index <= to_out_index(match_r);
      pend_r.found       <= found_r;
      pend_r.distance    <= found_r ? limit_r : '0;
      pend_r.status      <= STATUS_OK;
    end

    if ((state_r == ST_FINISH) && out_free) begin
      out_r <= pend_r;
    end
  end

`ifndef ASSERT_OFF
  // fill count never passes the palette depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(PALETTE_DEPTH))
    else $error("entry count beyond palette depth");

  // only written entries reach the compare stage
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (CNT_W'(idx2_r) < entry_count_r))
    else $error("compare on an entry past the fill count");

  // pipeline is empty before a result is handed on
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!v1_r && !v2_r))
    else $error("result handed on with compares still in flight");

  // a found query never reports a distance above the threshold
  a_found_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && pend_r.found) |-> (pend_r.distance <= threshold_r))
    else $error("found distance above threshold");
`endif

endmodule

>>> sim/tb_nearest_palette_color_match.sv
`timescale 1ns / 1ps

module tb_nearest_palette_color_match;
  import npcm_pkg::*;

  localparam logic [1:0]        OP_UNUSED     = 2'd3;
  localparam logic [DIST_W-1:0] THRESHOLD_MAX = 18'd195075;
  localparam int unsigned       RUN_LIMIT     = 1000000;
  // minimum counted beats per random phase, unused op codes excluded; kept small
  // since the full-palette fill alone takes more than PALETTE_DEPTH beats
  localparam int                PHASE_ITEMS   = 6;

  // directed rows: predicted, typed-in result, or a threshold write whose
  // value rides in the distance field of the result
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_THRESH} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    in_beat_t  beat;
    out_beat_t result;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_beat_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_beat_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [DIST_W-1:0]  cfg_data;

  // palette shadow, updated on every accepted input beat
  logic [ENTRY_W-1:0]   pal_rgb [PALETTE_DEPTH];
  logic [CNT_W-1:0]     pal_count;
  logic [OUT_IDX_W-1:0] prev_match;
  logic [DIST_W-1:0]    thresh_now;

  out_beat_t   pending_results [$];
  out_beat_t   oldest_result;
  int          fail_count;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          stall_pct;
  int          counted_items;

  nearest_palette_color_match i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result of one operation against the palette shadow; updates the shadow
  function automatic out_beat_t predict_palette_op(input in_beat_t b);
    out_beat_t            r;
    logic [31:0]          limit;
    logic [31:0]          d;
    logic [31:0]          i;
    logic [OUT_IDX_W-1:0] best;
    int                   dr;
    int                   dg;
    int                   db;
    bit                   hit;
    r = '0;
    case (b.operation)
      OP_CLEAR: begin
        pal_count  = '0;
        prev_match = '0;
      end
      OP_APPEND: begin
        if (pal_count < PALETTE_DEPTH) begin
          pal_rgb[pal_count] = {b.red, b.green, b.blue};
          r.match_index      = pal_count[OUT_IDX_W-1:0];
          pal_count          = pal_count + 1'b1;
        end else begin
          // palette full, entry dropped
          r.status = STATUS_FULL;
        end
      end
      OP_QUERY: begin
        // running limit starts at the threshold; <= hands ties to later entries
        limit = thresh_now;
        best  = prev_match;
        hit   = 1'b0;
        for (i = 0; i < pal_count; i++) begin
          dr = int'(pal_rgb[i][23:16]) - int'(b.red);
          dg = int'(pal_rgb[i][15:8])  - int'(b.green);
          db = int'(pal_rgb[i][7:0])   - int'(b.blue);
          d  = dr * dr + dg * dg + db * db;
          if (d <= limit) begin
            limit = d;
            best  = i[OUT_IDX_W-1:0];
            hit   = 1'b1;
          end
        end
        prev_match    = best;
        r.match_index = best;
        r.found       = hit;
        r.distance    = hit ? limit[DIST_W-1:0] : '0;
      end
      default: begin
        // unused op code: no state change, all-zero result
      end
    endcase
    return r;
  endfunction

  // drive one beat and hold it until taken; then maybe go idle for a while
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t typed_result);
    out_beat_t predicted;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    predicted = predict_palette_op(b);
    pending_results.push_back(typed ? typed_result : predicted);
    if (b.operation != OP_UNUSED) counted_items++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_op(input logic [1:0] op, input logic [ENTRY_W-1:0] color);
    send_beat({op, color}, 1'b0, '0);
  endtask

  // sender stops until every result is back, then a few more cycles
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [DIST_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    thresh_now = value;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 75;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 75;
      end
      default: begin
        send_idle_pct = 30;
        stall_pct     = 30;
      end
    endcase
  endtask

  // channels lean toward the extremes so far-apart colors show up often
  function automatic logic [COLOR_W-1:0] random_channel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] random_color();
    return {random_channel(), random_channel(), random_channel()};
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] base,
                                                input int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COLOR_W-1:0];
  endfunction

  // most queries land near a stored entry so that the limit actually bites
  task automatic send_random_query();
    logic [ENTRY_W-1:0] base;
    int                 spread;
    if (pal_count == 0 || $urandom_range(99) < 15) begin
      send_op(OP_QUERY, random_color());
    end else begin
      base = pal_rgb[$urandom_range(pal_count - 1)];
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 3;
        2: spread = 12;
        default: spread = 40;
      endcase
      send_op(OP_QUERY, {nudge(base[23:16], spread), nudge(base[15:8], spread),
                         nudge(base[7:0], spread)});
    end
  endtask

  // clear (usually), fill a small palette with some duplicates, then query it
  task automatic run_sequence();
    int                 n;
    int                 k;
    logic [ENTRY_W-1:0] c;
    if (pal_count > 48 || $urandom_range(99) < 60) send_op(OP_CLEAR, random_color());
    n = $urandom_range(12);
    for (k = 0; k < n; k++) begin
      if (pal_count != 0 && $urandom_range(99) < 20) c = pal_rgb[$urandom_range(pal_count - 1)];
      else c = random_color();
      send_op(OP_APPEND, c);
    end
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_op(OP_UNUSED, random_color());
        1: send_op(OP_APPEND, random_color());
        default: send_random_query();
      endcase
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // result checker: every accepted beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.match_index !== oldest_result.match_index) begin
          $error("match_index: expected %0d, got %0d", oldest_result.match_index,
                 out_data.match_index);
          fail_count++;
        end
        if (out_data.found !== oldest_result.found) begin
          $error("found: expected %0d, got %0d", oldest_result.found, out_data.found);
          fail_count++;
        end
        if (out_data.distance !== oldest_result.distance) begin
          $error("distance: expected %0d, got %0d", oldest_result.distance,
                 out_data.distance);
          fail_count++;
        end
        if (out_data.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    int       phase;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    pal_count     = '0;
    prev_match    = '0;
    thresh_now    = THRESHOLD_RESET;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    counted_items = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // kind, op, color, then match_index, found, distance, status
    // empty palette after reset: previous match 0, nothing found
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h000000, 9'd0, 1'b0, 18'd0, STATUS_OK});
    // unused op code: zero result, no effect
    dir_rows.push_back({ROW_TYPED, OP_UNUSED, 24'hffffff, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'h000000, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'hffffff, 9'd1, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'h000000, 9'd2, 1'b0, 18'd0, STATUS_OK});
    // two equal exact hits: the later entry wins
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h000000, 9'd2, 1'b1, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'hffffff, 9'd1, 1'b1, 18'd0, STATUS_OK});
    // mid gray is out of reach: previous match comes back, found low
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h808080, 9'd1, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'h0a141e, 9'd3, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_PREDICT, OP_QUERY, 24'h0c1221, 29'd0});
    dir_rows.push_back({ROW_PREDICT, OP_QUERY, 24'h000014, 29'd0});
    // clear zeroes count and last match
    dir_rows.push_back({ROW_TYPED, OP_CLEAR, 24'h123456, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'hff00ff, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'hff0080, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'hff0080, 9'd0, 1'b1, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_UNUSED, 24'h000000, 9'd0, 1'b0, 18'd0, STATUS_OK});
    // widest threshold: black against white gives the largest distance
    dir_rows.push_back({ROW_THRESH, OP_CLEAR, 24'h000000, 9'd0, 1'b0, THRESHOLD_MAX, 1'b0});
    dir_rows.push_back({ROW_TYPED, OP_CLEAR, 24'hffffff, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'hffffff, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h000000, 9'd0, 1'b1, THRESHOLD_MAX,
                        STATUS_OK});
    // zero threshold: exact hits only
    dir_rows.push_back({ROW_THRESH, OP_CLEAR, 24'h000000, 9'd0, 1'b0, 18'd0, 1'b0});
    dir_rows.push_back({ROW_TYPED, OP_APPEND, 24'h000001, 9'd1, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h000000, 9'd0, 1'b0, 18'd0, STATUS_OK});
    dir_rows.push_back({ROW_TYPED, OP_QUERY, 24'h000001, 9'd1, 1'b1, 18'd0, STATUS_OK});

    foreach (dir_rows[n]) begin
      row = dir_rows[n];
      if (row.kind == ROW_THRESH) write_threshold(row.result.distance);
      else send_beat(row.beat, row.kind == ROW_TYPED, row.result);
    end

    // random phases: every idle mode, thresholds from zero to the top
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_threshold(THRESHOLD_RESET);
        1: write_threshold('0);
        2: write_threshold(THRESHOLD_MAX);
        4: write_threshold(DIST_W'($urandom_range(4096)));
        6: write_threshold(THRESHOLD_MAX);
        default: write_threshold(DIST_W'($urandom_range(THRESHOLD_MAX)));
      endcase
      set_idle_mode(phase % 4);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) run_sequence();
    end

    // full palette: fill every slot, overflow appends, then full-length scans
    write_threshold(THRESHOLD_RESET);
    set_idle_mode(3);
    send_op(OP_CLEAR, random_color());
    repeat (PALETTE_DEPTH) send_op(OP_APPEND, random_color());
    repeat (3) send_op(OP_APPEND, random_color());
    repeat (4) send_random_query();
    send_op(OP_QUERY, pal_rgb[PALETTE_DEPTH-1]);
    send_op(OP_CLEAR, random_color());
    send_random_query();

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/npcm_pkg.sv
sv/npcm_ram.sv
sv/nearest_palette_color_match.sv
sim/tb_nearest_palette_color_match.sv
